>>> hdl/lbfg_pkg.sv
// ----------------------------------------------------------------------------
// lbfg_pkg
// types, constants and divider step functions of the load based governor
// ----------------------------------------------------------------------------
package lbfg_pkg;

    localparam int HZ_W        = 32;
    localparam int RAW_TICK_W  = 32;
    localparam int PCT_W       = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int SCALE_BIT   = 24;
    localparam int SCALE_SHIFT = 7;
    localparam int TICK_W      = SCALE_BIT + 1;
    localparam int PROD_W      = TICK_W + HZ_W;
    localparam int LOAD_W      = TICK_W + PCT_W;
    localparam int N2_W        = PROD_W + PCT_W;
    localparam int DIV1_STEPS  = PROD_W;
    localparam int DIV2_STEPS  = HZ_W;
    localparam int LATENCY     = 4 + DIV1_STEPS + DIV2_STEPS;

    localparam logic [PCT_W-1:0] PERCENT    = 7'd100;
    localparam logic [PCT_W-1:0] UP_RESET   = 7'd80;
    localparam logic [PCT_W-1:0] DOWN_RESET = 7'd20;
    localparam logic [HZ_W-1:0]  ALL_ONES   = '1;

    localparam logic [CFG_IDX_W-1:0] REG_UP_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_DIFF    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIMPLE_MODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LIMIT    = 3'd4;

    typedef struct packed {
        logic            err;
        logic            use_div;
        logic [HZ_W-1:0] f_other;
    } side_t;

    typedef struct packed {
        logic [TICK_W-1:0] rem;
        logic [PROD_W-1:0] nq;
        logic [TICK_W-1:0] win;
    } div1_t;

    typedef struct packed {
        logic [PCT_W-1:0] rem;
        logic [HZ_W-1:0]  nq;
        logic             ovf;
    } div2_t;

    function automatic div1_t div1_step(div1_t x);
        logic [TICK_W:0] t;
        div1_t           y;
        t = {x.rem, x.nq[PROD_W-1]};
        y = x;
        if (t >= {1'b0, x.win})
        begin
            y.rem = TICK_W'(t - {1'b0, x.win});
            y.nq  = {x.nq[PROD_W-2:0], 1'b1};
        end
        else
        begin
            y.rem = t[TICK_W-1:0];
            y.nq  = {x.nq[PROD_W-2:0], 1'b0};
        end
        return y;
    endfunction

    function automatic div2_t div2_step(div2_t x, logic [PCT_W-1:0] d);
        logic [PCT_W:0] t;
        div2_t          y;
        t = {x.rem, x.nq[HZ_W-1]};
        y = x;
        if (t >= {1'b0, d})
        begin
            y.rem = PCT_W'(t - {1'b0, d});
            y.nq  = {x.nq[HZ_W-2:0], 1'b1};
        end
        else
        begin
            y.rem = t[PCT_W-1:0];
            y.nq  = {x.nq[HZ_W-2:0], 1'b0};
        end
        return y;
    endfunction

endpackage

>>> hdl/load_based_frequency_governor_top.sv
// ----------------------------------------------------------------------------
// load_based_frequency_governor_top
// ondemand style frequency decision, one load sample per cycle
// ----------------------------------------------------------------------------
// A request is taken in every cycle in which start is high; busy is always
// low. Its result appears with done after it passes one input stage, one
// decision stage that also forms the busy-times-frequency product, a 57
// stage restoring divider by the window length, a percent scaling stage and
// a 32 stage divider by the band midpoint, then the output register. Results
// are shown for one cycle only and cannot be stalled. Configuration writes
// are taken at once and must be made while no request is in flight.
module load_based_frequency_governor_top
    import lbfg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [RAW_TICK_W-1:0] busy_ticks,
    input  logic [RAW_TICK_W-1:0] window_ticks,
    input  logic [HZ_W-1:0]       current_hz,
    input  logic [HZ_W-1:0]       previous_hz,
    input  logic                  status_failed,
    output logic                  done,
    output logic [HZ_W-1:0]       target_hz,
    output logic                  error
);

    logic [PCT_W-1:0] up_reg;
    logic [PCT_W-1:0] down_reg;
    logic             simple_reg;
    logic [HZ_W-1:0]  min_reg;
    logic [HZ_W-1:0]  max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg     <= UP_RESET;
            down_reg   <= DOWN_RESET;
            simple_reg <= 1'b0;
            min_reg    <= '0;
            max_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_UP_THRESHOLD: up_reg     <= cfg_data[PCT_W-1:0];
                REG_DOWN_DIFF:    down_reg   <= cfg_data[PCT_W-1:0];
                REG_SIMPLE_MODE:  simple_reg <= cfg_data[0];
                REG_MIN_LIMIT:    min_reg    <= cfg_data[HZ_W-1:0];
                REG_MAX_LIMIT:    max_reg    <= cfg_data[HZ_W-1:0];
                default:          ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic [HZ_W-1:0]  top_hz;
    logic [PCT_W-1:0] half_down;
    logic [PCT_W-1:0] mid_div;
    assign top_hz    = (max_reg != '0) ? max_reg : ALL_ONES;
    assign half_down = down_reg >> 1;
    assign mid_div   = PCT_W'(up_reg - half_down);

    // input stage with scaling
    logic              a_valid_reg;
    logic [TICK_W-1:0] a_busy_reg;
    logic [TICK_W-1:0] a_win_reg;
    logic [HZ_W-1:0]   a_cur_reg;
    logic [HZ_W-1:0]   a_prev_reg;
    logic              a_err_reg;
    logic              big_next;
    logic [TICK_W-1:0] a_busy_next;
    logic [TICK_W-1:0] a_win_next;

    always_comb
    begin
        big_next = (busy_ticks[RAW_TICK_W-1:SCALE_BIT] != '0) ||
                   (window_ticks[RAW_TICK_W-1:SCALE_BIT] != '0);
        if (big_next)
        begin
            a_busy_next = TICK_W'(busy_ticks >> SCALE_SHIFT);
            a_win_next  = TICK_W'(window_ticks >> SCALE_SHIFT);
        end
        else
        begin
            a_busy_next = busy_ticks[TICK_W-1:0];
            a_win_next  = window_ticks[TICK_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        a_busy_reg <= a_busy_next;
        a_win_reg  <= a_win_next;
        a_cur_reg  <= current_hz;
        a_prev_reg <= previous_hz;
        a_err_reg  <= status_failed;
    end

    // decision stage and product
    logic [LOAD_W-1:0] load;
    logic [LOAD_W-1:0] win_up;
    logic [LOAD_W-1:0] win_down;
    logic [LOAD_W-1:0] win_band;
    side_t             b_side_next;
    logic              b_valid_reg;
    side_t             b_side_reg;
    logic [PROD_W-1:0] b_prod_reg;
    logic [TICK_W-1:0] b_win_reg;

    always_comb
    begin
        load     = LOAD_W'(a_busy_reg) * LOAD_W'(PERCENT);
        win_up   = LOAD_W'(a_win_reg) * LOAD_W'(up_reg);
        win_down = LOAD_W'(a_win_reg) * LOAD_W'(down_reg);
        win_band = LOAD_W'(a_win_reg) * LOAD_W'(PCT_W'(up_reg - down_reg));
        b_side_next.err     = 1'b0;
        b_side_next.use_div = 1'b0;
        b_side_next.f_other = top_hz;
        if (a_err_reg)
        begin
            b_side_next.err     = 1'b1;
            b_side_next.f_other = '0;
        end
        else if (simple_reg)
        begin
            if (load > win_up)
                b_side_next.f_other = top_hz;
            else if (load < win_down)
                b_side_next.f_other = min_reg;
            else
                b_side_next.f_other = a_prev_reg;
        end
        else if (a_win_reg == '0 || load > win_up || a_cur_reg == '0)
            b_side_next.f_other = top_hz;
        else if (down_reg > up_reg || load > win_band)
            b_side_next.f_other = a_cur_reg;
        else if (half_down >= up_reg)
            b_side_next.f_other = top_hz;
        else
            b_side_next.use_div = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        b_side_reg <= b_side_next;
        b_prod_reg <= PROD_W'(a_busy_reg) * PROD_W'(a_cur_reg);
        b_win_reg  <= a_win_reg;
    end

    // divider by window length
    div1_t                 d1_reg [DIV1_STEPS];
    side_t                 s1_reg [DIV1_STEPS];
    logic [DIV1_STEPS-1:0] v1_reg;
    div1_t                 d1_entry;

    assign d1_entry = '{rem: '0, nq: b_prod_reg, win: b_win_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= '0;
        else
            v1_reg <= {v1_reg[DIV1_STEPS-2:0], b_valid_reg};
    end

    for (genvar i = 0; i < DIV1_STEPS; i++)
    begin : g_div1
        if (i == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                d1_reg[i] <= div1_step(d1_entry);
                s1_reg[i] <= b_side_reg;
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                d1_reg[i] <= div1_step(d1_reg[i-1]);
                s1_reg[i] <= s1_reg[i-1];
            end
        end
    end

    // percent scaling and overflow test
    logic [N2_W-1:0] n2;
    logic            c_valid_reg;
    side_t           c_side_reg;
    div2_t           c_div_reg;
    div2_t           c_div_next;

    always_comb
    begin
        n2             = N2_W'(d1_reg[DIV1_STEPS-1].nq) * N2_W'(PERCENT);
        c_div_next.ovf = n2[N2_W-1:HZ_W] >= (N2_W-HZ_W)'(mid_div);
        c_div_next.rem = n2[HZ_W+PCT_W-1:HZ_W];
        c_div_next.nq  = n2[HZ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else
            c_valid_reg <= v1_reg[DIV1_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        c_side_reg <= s1_reg[DIV1_STEPS-1];
        c_div_reg  <= c_div_next;
    end

    // divider by band midpoint
    div2_t                 d2_reg [DIV2_STEPS];
    side_t                 s2_reg [DIV2_STEPS];
    logic [DIV2_STEPS-1:0] v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= '0;
        else
            v2_reg <= {v2_reg[DIV2_STEPS-2:0], c_valid_reg};
    end

    for (genvar j = 0; j < DIV2_STEPS; j++)
    begin : g_div2
        if (j == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                d2_reg[j] <= div2_step(c_div_reg, mid_div);
                s2_reg[j] <= c_side_reg;
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                d2_reg[j] <= div2_step(d2_reg[j-1], mid_div);
                s2_reg[j] <= s2_reg[j-1];
            end
        end
    end

    // saturation, clamping and output register
    logic [HZ_W-1:0] target_next;
    logic            done_reg;
    logic [HZ_W-1:0] target_reg;
    logic            error_reg;

    always_comb
    begin
        if (d2_reg[DIV2_STEPS-1].ovf)
            target_next = ALL_ONES;
        else
            target_next = d2_reg[DIV2_STEPS-1].nq;
        if (min_reg != '0 && target_next < min_reg)
            target_next = min_reg;
        if (max_reg != '0 && target_next > max_reg)
            target_next = max_reg;
        if (!s2_reg[DIV2_STEPS-1].use_div)
            target_next = s2_reg[DIV2_STEPS-1].f_other;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v2_reg[DIV2_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        error_reg  <= s2_reg[DIV2_STEPS-1].err;
    end

    assign done      = done_reg;
    assign target_hz = target_reg;
    assign error     = error_reg;

endmodule

>>> hdl/lbfg_checker.sv
// ----------------------------------------------------------------------------
// lbfg_checker
// port level checks of the load based governor, bound to the top level
// ----------------------------------------------------------------------------
module lbfg_checker
    import lbfg_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  status_failed,
    input logic                  done,
    input logic [HZ_W-1:0]       target_hz,
    input logic                  error
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without request");

    a_error_follows_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> error == $past(status_failed, LATENCY))
        else $error("error flag does not match request status");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && error |-> target_hz == '0)
        else $error("failed status gave nonzero target");

endmodule

bind load_based_frequency_governor_top lbfg_checker u_lbfg_checker (.*);
